// ----- src/tmt_pkg.sv -----
// ----------------------------------------------------------------------------
// tmt_pkg
// Shared types, codes and lookup functions of the tagged message tokenizer.
// ----------------------------------------------------------------------------
package tmt_pkg;

  localparam int unsigned TypeMaxDef = 16;
  localparam int unsigned NumKnown   = 14;
  localparam int unsigned QDepth     = 8;

  localparam logic [7:0] ChAmp   = 8'h26;
  localparam logic [7:0] ChLbr   = 8'h5b;
  localparam logic [7:0] ChRbr   = 8'h5d;
  localparam logic [7:0] ChComma = 8'h2c;
  localparam logic [7:0] ChEq    = 8'h3d;

  localparam logic [1:0] ModeKeepAll = 2'd0;
  localparam logic [1:0] ModeListed  = 2'd1;
  localparam logic       RegFilterMode = 1'b0;

  typedef enum logic [3:0] {
    EV_TEXT_CHAR = 4'd0,
    EV_TYPE_CHAR = 4'd1,
    EV_KEY_CHAR  = 4'd2,
    EV_VAL_CHAR  = 4'd3,
    EV_TEXT_END  = 4'd4,
    EV_PAIR_END  = 4'd5,
    EV_CODE_END  = 4'd6,
    EV_CODE_DISC = 4'd7,
    EV_TYPE_END  = 4'd8
  } event_e;

  typedef enum logic [1:0] {
    PH_TEXT  = 2'd0,
    PH_TYPE  = 2'd1,
    PH_KEY   = 2'd2,
    PH_VALUE = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FEED,
    ST_CEND,
    ST_FLUSH_RD,
    ST_FLUSH_EM,
    ST_END,
    ST_LAST
  } state_e;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_FEED,
    CMD_RELEASE,
    CMD_CEND,
    CMD_FLUSH_RD,
    CMD_FLUSH_EM,
    CMD_TEND,
    CMD_END,
    CMD_LAST
  } cmd_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [3:0] event_res;
    logic [7:0] char_value;
    logic       type_truncated;
    logic       last_of_run;
  } out_item_t;

  typedef struct packed {
    cmd_e cmd;
  } tmt_cmd_t;

  typedef struct packed {
    logic q_empty;
    logic eom;
    logic pend_busy;
    logic feed_cend;
    logic feed_flush;
    logic flush_more;
    logic can_emit;
    logic stage_v;
    logic out_free;
  } tmt_status_t;

  function automatic logic [3:0] kt_len(input logic [3:0] k);
    logic [3:0] n;
    case (k)
      4'd0:    n = 4'd4;
      4'd1:    n = 4'd5;
      4'd2:    n = 4'd4;
      4'd3:    n = 4'd5;
      4'd4:    n = 4'd6;
      4'd5:    n = 4'd2;
      4'd6:    n = 4'd3;
      4'd7:    n = 4'd4;
      4'd8:    n = 4'd9;
      4'd9:    n = 4'd5;
      4'd10:   n = 4'd5;
      4'd11:   n = 4'd7;
      4'd12:   n = 4'd8;
      4'd13:   n = 4'd5;
      default: n = 4'd0;
    endcase
    return n;
  endfunction

  // Character at position pos of known type k, zero past its end.
  function automatic logic [7:0] kt_char(input logic [3:0] k, input logic [3:0] pos);
    logic [71:0] w;
    logic [3:0]  n;
    int          idx;
    case (k)
      4'd0:    w = 72'("text");
      4'd1:    w = 72'("emoji");
      4'd2:    w = 72'("face");
      4'd3:    w = 72'("image");
      4'd4:    w = 72'("record");
      4'd5:    w = 72'("at");
      4'd6:    w = 72'("rps");
      4'd7:    w = 72'("dice");
      4'd8:    w = 72'("anonymous");
      4'd9:    w = 72'("shake");
      4'd10:   w = 72'("share");
      4'd11:   w = 72'("contact");
      4'd12:   w = 72'("location");
      4'd13:   w = 72'("music");
      default: w = '0;
    endcase
    n = kt_len(k);
    if (pos < n) begin
      idx = 8 * (int'(n) - 1 - int'(pos));
      return w[idx +: 8];
    end
    return 8'h00;
  endfunction

  // Tail of escape k after the ampersand: #91; #93; amp; #44;
  function automatic logic [7:0] esc_tail(input logic [1:0] k, input logic [1:0] p);
    logic [31:0] w;
    case (k)
      2'd0:    w = "#91;";
      2'd1:    w = "#93;";
      2'd2:    w = "amp;";
      default: w = "#44;";
    endcase
    return w[8*(3-int'(p)) +: 8];
  endfunction

  function automatic logic [7:0] esc_char(input logic [1:0] k);
    logic [7:0] c;
    case (k)
      2'd0:    c = ChLbr;
      2'd1:    c = ChRbr;
      2'd2:    c = ChAmp;
      default: c = ChComma;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] tag_char(input logic [1:0] p);
    logic [7:0] c;
    case (p)
      2'd0:    c = 8'h43;
      2'd1:    c = 8'h51;
      default: c = 8'h3a;
    endcase
    return c;
  endfunction

endpackage

// ----- src/tagged_message_tokenizer.sv -----
// ----------------------------------------------------------------------------
// tagged_message_tokenizer
// Splits message bytes into tagged text, type, key and value characters.
// ----------------------------------------------------------------------------
// Usage:
// - Input channel (in_valid_i/in_ready_o/in_data_i) takes one raw byte per
//   request plus an end-of-message flag. Output channel returns a stream of
//   tagged results; the last result caused by a byte carries last_of_run.
// - One byte is in work at a time. A plain byte passes the accept, the
//   feed, a step that finds the byte queue empty and one that releases the
//   last result. A further step comes for each byte replayed from the
//   lookahead, each lookahead released at message end, the message end and
//   a code end; when a kept type closes, each type character takes a read
//   and an emit step and a type-end step follows. The sequencer walking
//   the byte queue sets these steps; a new byte is taken only once the
//   last one is through.
// - Results pass through a staging register and an output register, so the
//   first result of a byte appears when the next one is made or the byte
//   finishes; a stalled receiver holds the sequencer once both are full.
// - Reset clears the parse state and sets filter_mode to keep all codes. The
//   user writes filter_mode over APB only in idle; the block does not check.
// ----------------------------------------------------------------------------
module tagged_message_tokenizer #(
  parameter int unsigned TYPE_MAX = tmt_pkg::TypeMaxDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  tmt_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output tmt_pkg::out_item_t out_data_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import tmt_pkg::*;

  logic [1:0]  mode_q;
  tmt_cmd_t    cmd;
  tmt_status_t st;

  // Filter mode register at byte address zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeKeepAll;
    end else if (psel && penable && pwrite && paddr[2] == RegFilterMode) begin
      mode_q <= pwdata[1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegFilterMode) ? {30'b0, mode_q} : 32'b0;

  tmt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  tmt_dp #(
    .TYPE_MAX (TYPE_MAX)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .st_o          (st),
    .in_data_i     (in_data_i),
    .filter_mode_i (mode_q),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_data_o    (out_data_o)
  );

endmodule

// ----- src/tmt_ctrl.sv -----
// ----------------------------------------------------------------------------
// tmt_ctrl
// Sequencer: walks the byte queue, the type flush and the message end.
// ----------------------------------------------------------------------------
module tmt_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  tmt_pkg::tmt_status_t st_i,
  output tmt_pkg::tmt_cmd_t    cmd_o
);
  import tmt_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o.cmd  = CMD_NONE;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.cmd = CMD_LOAD;
          state_d   = ST_FEED;
        end
      end
      ST_FEED: begin
        if (st_i.can_emit) begin
          if (!st_i.q_empty) begin
            cmd_o.cmd = CMD_FEED;
            if (st_i.feed_cend) begin
              state_d = ST_CEND;
            end else if (st_i.feed_flush) begin
              state_d = ST_FLUSH_RD;
            end
          end else if (st_i.eom && st_i.pend_busy) begin
            cmd_o.cmd = CMD_RELEASE;
          end else if (st_i.eom) begin
            state_d = ST_END;
          end else begin
            state_d = ST_LAST;
          end
        end
      end
      ST_CEND: begin
        if (st_i.can_emit) begin
          cmd_o.cmd = CMD_CEND;
          state_d   = ST_FEED;
        end
      end
      ST_FLUSH_RD: begin
        if (st_i.flush_more) begin
          cmd_o.cmd = CMD_FLUSH_RD;
          state_d   = ST_FLUSH_EM;
        end else if (st_i.can_emit) begin
          cmd_o.cmd = CMD_TEND;
          state_d   = ST_FEED;
        end
      end
      ST_FLUSH_EM: begin
        if (st_i.can_emit) begin
          cmd_o.cmd = CMD_FLUSH_EM;
          state_d   = ST_FLUSH_RD;
        end
      end
      ST_END: begin
        if (st_i.can_emit) begin
          cmd_o.cmd = CMD_END;
          state_d   = ST_LAST;
        end
      end
      ST_LAST: begin
        if (!st_i.stage_v) begin
          state_d = ST_IDLE;
        end else if (st_i.out_free) begin
          cmd_o.cmd = CMD_LAST;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// ----- src/tmt_dp.sv -----
// ----------------------------------------------------------------------------
// tmt_dp
// Datapath: byte queue, opener lookahead, type buffer, result staging.
// ----------------------------------------------------------------------------
module tmt_dp #(
  parameter int unsigned TYPE_MAX = tmt_pkg::TypeMaxDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tmt_pkg::tmt_cmd_t    cmd_i,
  output tmt_pkg::tmt_status_t st_o,
  input  tmt_pkg::in_item_t    in_data_i,
  input  logic [1:0]           filter_mode_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output tmt_pkg::out_item_t   out_data_o
);
  import tmt_pkg::*;

  localparam int unsigned LW = $clog2(TYPE_MAX + 1);
  localparam int unsigned AW = $clog2(TYPE_MAX);

  logic [7:0]          q_q [QDepth];
  logic [7:0]          q_d [QDepth];
  logic [3:0]          qn_q, qn_d;
  logic                eom_q, eom_d;
  logic [7:0]          pb_q [4];
  logic [2:0]          pc_q, pc_d;
  logic                po_q, po_d;
  logic                pb_we;
  logic [1:0]          pb_wa;
  phase_e              ph_q, ph_d;
  logic [LW-1:0]       tl_q, tl_d;
  logic                tlong_q, tlong_d;
  logic                tseen_q, tseen_d;
  logic                kept_q, kept_d;
  logic [NumKnown-1:0] mask_q, mask_d;
  logic [LW-1:0]       fidx_q, fidx_d;
  logic [7:0]          rd_q;
  logic [7:0]          mem [TYPE_MAX];
  logic                ram_we;
  out_item_t           stage_q, stage_d, out_q, out_d;
  logic                stage_v_q, stage_v_d, out_v_q, out_v_d;

  logic                emit_v;
  logic [3:0]          emit_ev;
  logic [7:0]          emit_ch;
  logic                do_del, do_tadd, do_clear;
  logic [7:0]          del_ch, tadd_ch;
  logic [7:0]          b;
  logic [1:0]          p;
  logic                open_ok, esc_full, esc_part, pre_ok, listed, kept_new;
  logic [1:0]          esc_k;
  logic                dec_cend, dec_flush;
  logic                out_free;

  assign b        = q_q[0];
  assign p        = 2'(pc_q - 3'd1);
  assign out_free = !out_v_q || out_ready_i;

  // Escape and opener matching against the held bytes.
  always_comb begin
    esc_full = 1'b0;
    esc_part = 1'b0;
    esc_k    = 2'd0;
    for (int k = 0; k < 4; k++) begin
      pre_ok = (ph_q != PH_TEXT) || (k < 3);
      for (int i = 0; i < 3; i++) begin
        if (i < int'(p) && pb_q[i+1] != esc_tail(2'(k), 2'(i))) pre_ok = 1'b0;
      end
      if (pre_ok && esc_tail(2'(k), p) == b) begin
        if (p == 2'd3) begin
          esc_full = 1'b1;
          esc_k    = 2'(k);
        end else begin
          esc_part = 1'b1;
        end
      end
    end
    open_ok = po_q && (p != 2'd3) && (b == tag_char(p));
  end

  always_comb begin
    listed = 1'b0;
    for (int k = 0; k < NumKnown; k++) begin
      if (mask_q[k] && tl_q == LW'(kt_len(4'(k)))) listed = 1'b1;
    end
    if (tlong_q) listed = 1'b0;
    if (filter_mode_i == ModeKeepAll) kept_new = 1'b1;
    else if (filter_mode_i == ModeListed) kept_new = listed;
    else kept_new = 1'b0;
  end

  always_comb begin
    dec_cend  = 1'b0;
    dec_flush = 1'b0;
    if (pc_q == 3'd0 && b != ChAmp) begin
      if (ph_q == PH_TYPE && b == ChComma) dec_flush = kept_new;
      if (ph_q == PH_VALUE && b == ChRbr) dec_cend = kept_q;
    end
  end

  always_comb begin
    q_d       = q_q;
    qn_d      = qn_q;
    eom_d     = eom_q;
    pc_d      = pc_q;
    po_d      = po_q;
    pb_we     = 1'b0;
    pb_wa     = pc_q[1:0];
    ph_d      = ph_q;
    tl_d      = tl_q;
    tlong_d   = tlong_q;
    tseen_d   = tseen_q;
    kept_d    = kept_q;
    mask_d    = mask_q;
    fidx_d    = fidx_q;
    ram_we    = 1'b0;
    emit_v    = 1'b0;
    emit_ev   = EV_TEXT_CHAR;
    emit_ch   = 8'h00;
    do_del    = 1'b0;
    do_tadd   = 1'b0;
    do_clear  = 1'b0;
    del_ch    = b;
    tadd_ch   = b;
    case (cmd_i.cmd)
      CMD_LOAD: begin
        q_d[0] = in_data_i.in_byte;
        qn_d   = 4'd1;
        eom_d  = in_data_i.end_of_message;
      end
      CMD_FEED: begin
        for (int j = 0; j < QDepth - 1; j++) q_d[j] = q_q[j+1];
        qn_d = qn_q - 4'd1;
        if (pc_q != 3'd0) begin
          if (po_q && open_ok) begin
            if (p == 2'd2) begin
              pc_d = 3'd0;
              po_d = 1'b0;
              if (tseen_q) begin
                emit_v  = 1'b1;
                emit_ev = EV_TEXT_END;
              end
              tseen_d  = 1'b0;
              do_clear = 1'b1;
            end else begin
              pb_we = 1'b1;
              pc_d  = pc_q + 3'd1;
            end
          end else if (!po_q && esc_full) begin
            pc_d   = 3'd0;
            do_del = 1'b1;
            del_ch = esc_char(esc_k);
          end else if (!po_q && esc_part) begin
            pb_we = 1'b1;
            pc_d  = pc_q + 3'd1;
          end else begin
            // Drop the opener and replay the held bytes, this byte, the rest.
            for (int j = 0; j < QDepth; j++) begin
              if (j < int'(p)) q_d[j] = pb_q[2'(j + 1)];
              else if (j == int'(p)) q_d[j] = b;
              else q_d[j] = q_q[3'(j - int'(p))];
            end
            qn_d = ({2'b00, p} + qn_q > 4'(QDepth)) ? 4'(QDepth) : {2'b00, p} + qn_q;
            pc_d = 3'd0;
            po_d = 1'b0;
          end
        end else if (b == ChAmp) begin
          pb_we = 1'b1;
          pb_wa = 2'd0;
          pc_d  = 3'd1;
          po_d  = 1'b0;
        end else begin
          case (ph_q)
            PH_TEXT: begin
              if (b == ChLbr) begin
                pb_we = 1'b1;
                pb_wa = 2'd0;
                pc_d  = 3'd1;
                po_d  = 1'b1;
              end else begin
                do_del = 1'b1;
              end
            end
            PH_TYPE: begin
              if (b == ChComma) begin
                kept_d = kept_new;
                ph_d   = PH_KEY;
                fidx_d = '0;
              end else begin
                do_tadd = 1'b1;
              end
            end
            PH_KEY: begin
              if (b == ChEq) ph_d = PH_VALUE;
              else do_del = 1'b1;
            end
            default: begin
              if (b == ChRbr) begin
                if (kept_q) begin
                  emit_v  = 1'b1;
                  emit_ev = EV_PAIR_END;
                end else begin
                  do_clear = 1'b1;
                end
              end else if (b == ChComma) begin
                emit_v  = kept_q;
                emit_ev = EV_PAIR_END;
                ph_d    = PH_KEY;
              end else begin
                do_del = 1'b1;
              end
            end
          endcase
        end
      end
      CMD_RELEASE: begin
        for (int j = 0; j < QDepth; j++) begin
          q_d[j] = (j < int'(p)) ? pb_q[2'(j + 1)] : 8'h00;
        end
        qn_d = {2'b00, p};
        pc_d = 3'd0;
        po_d = 1'b0;
      end
      CMD_CEND: begin
        emit_v   = 1'b1;
        emit_ev  = EV_CODE_END;
        do_clear = 1'b1;
      end
      CMD_FLUSH_EM: begin
        emit_v  = 1'b1;
        emit_ev = EV_TYPE_CHAR;
        emit_ch = rd_q;
        fidx_d  = fidx_q + LW'(1);
      end
      CMD_TEND: begin
        emit_v  = 1'b1;
        emit_ev = EV_TYPE_END;
      end
      CMD_END: begin
        if (ph_q != PH_TEXT) begin
          emit_v  = 1'b1;
          emit_ev = EV_CODE_DISC;
        end else if (tseen_q) begin
          emit_v  = 1'b1;
          emit_ev = EV_TEXT_END;
        end
        tseen_d  = 1'b0;
        pc_d     = 3'd0;
        po_d     = 1'b0;
        do_clear = 1'b1;
      end
      default: ;
    endcase

    if (do_del) begin
      case (ph_q)
        PH_TEXT: begin
          emit_v  = 1'b1;
          emit_ev = EV_TEXT_CHAR;
          emit_ch = del_ch;
          tseen_d = 1'b1;
        end
        PH_TYPE: begin
          do_tadd = 1'b1;
          tadd_ch = del_ch;
        end
        PH_KEY: begin
          emit_v  = kept_q;
          emit_ev = EV_KEY_CHAR;
          emit_ch = del_ch;
        end
        default: begin
          emit_v  = kept_q;
          emit_ev = EV_VAL_CHAR;
          emit_ch = del_ch;
        end
      endcase
    end

    if (do_tadd) begin
      if (tl_q < LW'(TYPE_MAX)) begin
        ram_we = 1'b1;
        tl_d   = tl_q + LW'(1);
        for (int k = 0; k < NumKnown; k++) begin
          if (!(tl_q < LW'(kt_len(4'(k))) && kt_char(4'(k), tl_q[3:0]) == tadd_ch)) begin
            mask_d[k] = 1'b0;
          end
        end
      end else begin
        tlong_d = 1'b1;
      end
    end

    if (do_clear) begin
      ph_d    = (cmd_i.cmd == CMD_FEED && pc_q != 3'd0) ? PH_TYPE : PH_TEXT;
      tl_d    = '0;
      tlong_d = 1'b0;
      kept_d  = 1'b1;
      mask_d  = '1;
    end
  end

  // Result staging: one result waits so the last of a run can be marked.
  always_comb begin
    stage_d   = stage_q;
    stage_v_d = stage_v_q;
    out_d     = out_q;
    out_v_d   = out_v_q && !out_ready_i;
    if (emit_v) begin
      if (stage_v_q) begin
        out_d   = stage_q;
        out_v_d = 1'b1;
      end
      stage_d.event_res      = emit_ev;
      stage_d.char_value     = emit_ch;
      stage_d.type_truncated = tlong_q;
      stage_d.last_of_run    = 1'b0;
      stage_v_d              = 1'b1;
    end
    if (cmd_i.cmd == CMD_LAST) begin
      out_d             = stage_q;
      out_d.last_of_run = 1'b1;
      out_v_d           = 1'b1;
      stage_v_d         = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qn_q      <= '0;
      eom_q     <= 1'b0;
      pc_q      <= '0;
      po_q      <= 1'b0;
      ph_q      <= PH_TEXT;
      tl_q      <= '0;
      tlong_q   <= 1'b0;
      tseen_q   <= 1'b0;
      kept_q    <= 1'b1;
      mask_q    <= '1;
      fidx_q    <= '0;
      stage_v_q <= 1'b0;
      out_v_q   <= 1'b0;
    end else begin
      qn_q      <= qn_d;
      eom_q     <= eom_d;
      pc_q      <= pc_d;
      po_q      <= po_d;
      ph_q      <= ph_d;
      tl_q      <= tl_d;
      tlong_q   <= tlong_d;
      tseen_q   <= tseen_d;
      kept_q    <= kept_d;
      mask_q    <= mask_d;
      fidx_q    <= fidx_d;
      stage_v_q <= stage_v_d;
      out_v_q   <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q     <= q_d;
    stage_q <= stage_d;
    out_q   <= out_d;
    if (pb_we) pb_q[pb_wa] <= b;
  end

  // Type buffer memory.
  always_ff @(posedge clk_i) begin
    if (ram_we) mem[tl_q[AW-1:0]] <= tadd_ch;
    if (cmd_i.cmd == CMD_FLUSH_RD) rd_q <= mem[fidx_q[AW-1:0]];
  end

  always_comb begin
    st_o.q_empty    = (qn_q == 4'd0);
    st_o.eom        = eom_q;
    st_o.pend_busy  = (pc_q != 3'd0);
    st_o.feed_cend  = dec_cend;
    st_o.feed_flush = dec_flush;
    st_o.flush_more = (fidx_q < tl_q);
    st_o.can_emit   = !stage_v_q || out_free;
    st_o.stage_v    = stage_v_q;
    st_o.out_free   = out_free;
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

endmodule

// ----- src/tmt_checker.sv -----
// ----------------------------------------------------------------------------
// tmt_checker
// Port-level checks of the tokenizer, bound to the top level.
// ----------------------------------------------------------------------------
module tmt_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input tmt_pkg::out_item_t out_data_o,
  input logic               pready
);
  import tmt_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  a_event_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.event_res <= EV_TYPE_END)
    else $error("event code out of range");

  a_mark_no_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.event_res >= EV_TEXT_END |-> out_data_o.char_value == 8'h00)
    else $error("mark result carries a character");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind tagged_message_tokenizer tmt_checker u_tmt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o),
  .pready      (pready)
);
